FILE: hw/rtl/fnsc_pkg.sv
package fnsc_pkg;

  // Widths of the stream fields and the tracking counters.
  localparam int unsigned UnitW  = 16;
  localparam int unsigned CountW = 3;

  // Saturation points of the counters.
  localparam logic [CountW-1:0] UnitSat = CountW'(4);
  localparam logic [CountW-1:0] BaseSat = CountW'(5);

  // Character codes used by the rules.
  localparam logic [UnitW-1:0] CharCtrlEnd  = 16'h0020;
  localparam logic [UnitW-1:0] CharSpace    = 16'h0020;
  localparam logic [UnitW-1:0] CharDot      = 16'h002E;
  localparam logic [UnitW-1:0] CharSlash    = 16'h002F;
  localparam logic [UnitW-1:0] CharBslash   = 16'h005C;
  localparam logic [UnitW-1:0] CharColon    = 16'h003A;
  localparam logic [UnitW-1:0] CharStar     = 16'h002A;
  localparam logic [UnitW-1:0] CharQuest    = 16'h003F;
  localparam logic [UnitW-1:0] CharQuote    = 16'h0022;
  localparam logic [UnitW-1:0] CharLess     = 16'h003C;
  localparam logic [UnitW-1:0] CharGreater  = 16'h003E;
  localparam logic [UnitW-1:0] CharPipe     = 16'h007C;
  localparam logic [UnitW-1:0] CharDigit1   = 16'h0031;
  localparam logic [UnitW-1:0] CharDigit9   = 16'h0039;
  localparam logic [UnitW-1:0] CharUpperA   = 16'h0041;
  localparam logic [UnitW-1:0] CharUpperZ   = 16'h005A;
  localparam logic [UnitW-1:0] CaseOffset   = 16'h0020;

  // One item of the input stream.
  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             end_of_name;
  } fnsc_item_t;

  // ASCII letters are lowercased; every other unit passes unchanged.
  function automatic logic [UnitW-1:0] lower_ascii(input logic [UnitW-1:0] u);
    if (u >= CharUpperA && u <= CharUpperZ) begin
      return u + CaseOffset;
    end
    return u;
  endfunction

  // Control units and the characters that a file name may not hold.
  function automatic logic is_forbidden(input logic [UnitW-1:0] u);
    return (u < CharCtrlEnd) || (u == CharSlash) || (u == CharBslash) ||
           (u == CharColon) || (u == CharStar) || (u == CharQuest) ||
           (u == CharQuote) || (u == CharLess) || (u == CharGreater) ||
           (u == CharPipe);
  endfunction

  // Three lowercased units against a three-letter ASCII word.
  function automatic logic trio_is(input logic [UnitW-1:0] a,
                                   input logic [UnitW-1:0] b,
                                   input logic [UnitW-1:0] c,
                                   input logic [23:0]      word);
    return (a == {8'h00, word[23:16]}) && (b == {8'h00, word[15:8]}) &&
           (c == {8'h00, word[7:0]});
  endfunction

endpackage

FILE: hw/rtl/fnsc_tracker.sv
module fnsc_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  fnsc_pkg::fnsc_item_t item,
  output logic                safe
);
  import fnsc_pkg::*;

  logic [CountW-1:0] unit_count_r, unit_count_nxt;
  logic [CountW-1:0] base_count_r, base_count_nxt;
  logic              dot_seen_r, dot_seen_nxt;
  logic              bad_seen_r, bad_seen_nxt;
  logic [UnitW-1:0]  first_unit_r, first_unit_nxt;
  logic [UnitW-1:0]  second_low_r, second_low_nxt;
  logic [UnitW-1:0]  third_low_r, third_low_nxt;
  logic [UnitW-1:0]  fourth_unit_r, fourth_unit_nxt;
  logic [UnitW-1:0]  last_unit_r, last_unit_nxt;

  logic [UnitW-1:0]  first_low;
  logic              short_device;
  logic              port_device;
  logic              digit_ok;
  logic              dot_now;

  // Verdict on the name gathered so far.
  always_comb begin
    first_low    = lower_ascii(first_unit_r);
    short_device = (base_count_r == CountW'(3)) &&
                   (trio_is(first_low, second_low_r, third_low_r, "con") ||
                    trio_is(first_low, second_low_r, third_low_r, "prn") ||
                    trio_is(first_low, second_low_r, third_low_r, "aux") ||
                    trio_is(first_low, second_low_r, third_low_r, "nul"));
    digit_ok     = (fourth_unit_r >= CharDigit1) && (fourth_unit_r <= CharDigit9);
    port_device  = (base_count_r == CountW'(4)) && digit_ok &&
                   (trio_is(first_low, second_low_r, third_low_r, "com") ||
                    trio_is(first_low, second_low_r, third_low_r, "lpt"));
    safe = (unit_count_r != '0) && !bad_seen_r &&
           (first_unit_r != CharSpace) && (last_unit_r != CharSpace) &&
           (last_unit_r != CharDot) && !short_device && !port_device;
  end

  // State update for one transfer: a terminator clears, a unit is recorded.
  always_comb begin
    unit_count_nxt  = unit_count_r;
    base_count_nxt  = base_count_r;
    dot_seen_nxt    = dot_seen_r;
    bad_seen_nxt    = bad_seen_r;
    first_unit_nxt  = first_unit_r;
    second_low_nxt  = second_low_r;
    third_low_nxt   = third_low_r;
    fourth_unit_nxt = fourth_unit_r;
    last_unit_nxt   = last_unit_r;
    dot_now         = (item.code_unit == CharDot);
    if (step) begin
      if (item.end_of_name) begin
        unit_count_nxt  = '0;
        base_count_nxt  = '0;
        dot_seen_nxt    = 1'b0;
        bad_seen_nxt    = 1'b0;
        first_unit_nxt  = '0;
        second_low_nxt  = '0;
        third_low_nxt   = '0;
        fourth_unit_nxt = '0;
        last_unit_nxt   = '0;
      end else begin
        if (is_forbidden(item.code_unit)) begin
          bad_seen_nxt = 1'b1;
        end
        case (unit_count_r)
          CountW'(0): first_unit_nxt  = item.code_unit;
          CountW'(1): second_low_nxt  = lower_ascii(item.code_unit);
          CountW'(2): third_low_nxt   = lower_ascii(item.code_unit);
          CountW'(3): fourth_unit_nxt = item.code_unit;
          default: ;
        endcase
        if (unit_count_r < UnitSat) begin
          unit_count_nxt = unit_count_r + CountW'(1);
        end
        // The dot itself does not count toward the base.
        dot_seen_nxt = dot_seen_r | dot_now;
        if (!dot_seen_nxt && base_count_r < BaseSat) begin
          base_count_nxt = base_count_r + CountW'(1);
        end
        last_unit_nxt = item.code_unit;
      end
    end
  end

  // Name state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_count_r  <= '0;
      base_count_r  <= '0;
      dot_seen_r    <= 1'b0;
      bad_seen_r    <= 1'b0;
      first_unit_r  <= '0;
      second_low_r  <= '0;
      third_low_r   <= '0;
      fourth_unit_r <= '0;
      last_unit_r   <= '0;
    end else begin
      unit_count_r  <= unit_count_nxt;
      base_count_r  <= base_count_nxt;
      dot_seen_r    <= dot_seen_nxt;
      bad_seen_r    <= bad_seen_nxt;
      first_unit_r  <= first_unit_nxt;
      second_low_r  <= second_low_nxt;
      third_low_r   <= third_low_nxt;
      fourth_unit_r <= fourth_unit_nxt;
      last_unit_r   <= last_unit_nxt;
    end
  end

endmodule

FILE: hw/rtl/file_name_safety_check_core.sv
// Channel  | Ports                                        | Moves
// input    | in_valid, in_ready, in_code_unit, in_end_of_name | one code unit or a terminator
// result   | out_valid, out_ready, out_name_is_safe       | one verdict per terminator
//
// One item is taken per cycle. An item waits in the input register and updates the
// name state as it leaves it; a terminator also loads its verdict into the result
// register as it leaves. The input register stalls only while it holds a terminator
// and the result register is full and not being read.
// Reset is synchronous and active low; it empties both registers and clears the name state.
module file_name_safety_check_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [fnsc_pkg::UnitW-1:0] in_code_unit,
  input  logic                       in_end_of_name,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_name_is_safe
);
  import fnsc_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  fnsc_item_t item_r, item_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       safe_r, safe_nxt;
  logic       advance;
  logic       safe_now;

  // The held item moves on unless it is a terminator facing a full result register.
  always_comb begin
    advance  = in_valid_r && (!item_r.end_of_name || !out_valid_r || out_ready);
    in_ready = !in_valid_r || advance;
  end

  fnsc_tracker u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .safe  (safe_now)
  );

  // Next values of the input and result registers.
  always_comb begin
    in_valid_nxt = in_valid_r;
    item_nxt     = item_r;
    if (in_ready) begin
      in_valid_nxt = in_valid;
      item_nxt     = '{code_unit: in_code_unit, end_of_name: in_end_of_name};
    end
    out_valid_nxt = out_valid_r && !out_ready;
    safe_nxt      = safe_r;
    if (advance && item_r.end_of_name) begin
      out_valid_nxt = 1'b1;
      safe_nxt      = safe_now;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    safe_r <= safe_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_name_is_safe = safe_r;

endmodule

FILE: tb/tb_file_name_safety_check_core.sv
module tb_file_name_safety_check_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fnsc_pkg::*;

  // Tracks the name in flight and predicts one verdict per terminator.
  class verdict_board;
    logic [CountW-1:0] unit_cnt;
    logic [CountW-1:0] base_cnt;
    logic              dot_hit;
    logic              bad_hit;
    logic [UnitW-1:0]  first_u;
    logic [UnitW-1:0]  second_l;
    logic [UnitW-1:0]  third_l;
    logic [UnitW-1:0]  fourth_u;
    logic [UnitW-1:0]  last_u;
    logic              verdict_q[$];
    int unsigned       mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      unit_cnt = '0;
      base_cnt = '0;
      dot_hit  = 1'b0;
      bad_hit  = 1'b0;
      first_u  = '0;
      second_l = '0;
      third_l  = '0;
      fourth_u = '0;
      last_u   = '0;
    endfunction

    // Only ASCII capitals are folded.
    function logic [UnitW-1:0] fold_case(logic [UnitW-1:0] u);
      if (u >= CharUpperA && u <= CharUpperZ) begin
        return u + CaseOffset;
      end
      return u;
    endfunction

    function logic is_illegal_unit(logic [UnitW-1:0] u);
      return (u < CharCtrlEnd) || (u == CharSlash) || (u == CharBslash) ||
             (u == CharColon) || (u == CharStar) || (u == CharQuest) ||
             (u == CharQuote) || (u == CharLess) || (u == CharGreater) ||
             (u == CharPipe);
    endfunction

    function logic spells(logic [UnitW-1:0] a, logic [UnitW-1:0] b,
                          logic [UnitW-1:0] c, string word);
      return (a == {8'h00, word[0]}) && (b == {8'h00, word[1]}) &&
             (c == {8'h00, word[2]});
    endfunction

    // Reserved device bases: three-letter words, or COM/LPT with a digit 1 to 9.
    function logic is_device_base();
      logic [UnitW-1:0] a;
      a = fold_case(first_u);
      if (base_cnt == 3 && (spells(a, second_l, third_l, "con") ||
                            spells(a, second_l, third_l, "prn") ||
                            spells(a, second_l, third_l, "aux") ||
                            spells(a, second_l, third_l, "nul"))) begin
        return 1'b1;
      end
      return base_cnt == 4 && fourth_u >= CharDigit1 && fourth_u <= CharDigit9 &&
             (spells(a, second_l, third_l, "com") || spells(a, second_l, third_l, "lpt"));
    endfunction

    // Called for every input transfer.
    function void note_transfer(logic [UnitW-1:0] u, logic eon);
      logic safe;
      if (eon) begin
        safe = (unit_cnt != 0) && !bad_hit && (first_u != CharSpace) &&
               (last_u != CharSpace) && (last_u != CharDot) && !is_device_base();
        verdict_q.push_back(safe);
        clear();
        return;
      end
      if (is_illegal_unit(u)) begin
        bad_hit = 1'b1;
      end
      case (unit_cnt)
        0: first_u = u;
        1: second_l = fold_case(u);
        2: third_l = fold_case(u);
        3: fourth_u = u;
        default: ;
      endcase
      if (unit_cnt < UnitSat) begin
        unit_cnt = unit_cnt + 1'b1;
      end
      if (u == CharDot) begin
        dot_hit = 1'b1;
      end
      if (!dot_hit && base_cnt < BaseSat) begin
        base_cnt = base_cnt + 1'b1;
      end
      last_u = u;
    endfunction

    // Called for every result transfer.
    function void check_verdict(logic actual);
      logic predicted;
      if (verdict_q.size() == 0) begin
        $error("name_is_safe: result with none pending, actual %0b", actual);
        mismatches++;
        return;
      end
      predicted = verdict_q.pop_front();
      if (actual !== predicted) begin
        $error("name_is_safe: expected %0b actual %0b", predicted, actual);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [UnitW-1:0] in_code_unit;
  logic             in_end_of_name;
  logic             out_valid;
  logic             out_ready;
  logic             out_name_is_safe;

  verdict_board     board;
  logic [UnitW-1:0] name_buf[$];
  int unsigned      items_sent;
  bit               quiet;
  bit               hold_req;
  bit               run_live;

  file_name_safety_check_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_unit     (in_code_unit),
    .in_end_of_name   (in_end_of_name),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_name_is_safe (out_name_is_safe)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard limit on the run time.
  initial begin
    #200000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result transfers are checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_verdict(out_name_is_safe);
    end
  end

  // Receiver: random back-pressure, a quiet stretch, and one long hold-off on request.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = quiet ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end
  end

  // Offers one item and waits for its transfer; called at a falling edge.
  task automatic send_item(input logic [UnitW-1:0] u, input logic eon);
    while (!quiet && $urandom_range(0, 99) < 25) begin
      in_valid     = 1'b0;
      in_code_unit = UnitW'($urandom);
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_code_unit   = u;
    in_end_of_name = eon;
    do begin
      @(posedge clk);
    end while (!in_ready);
    board.note_transfer(u, eon);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends the buffered name and its terminator, whose unit carries random bits.
  task automatic send_buffered_name();
    foreach (name_buf[i]) begin
      send_item(name_buf[i], 1'b0);
    end
    send_item(UnitW'($urandom), 1'b1);
  endtask

  task automatic send_text(input string s);
    name_buf = {};
    for (int i = 0; i < s.len(); i++) begin
      name_buf.push_back({8'h00, s[i]});
    end
    send_buffered_name();
  endtask

  // Puts an ASCII letter into random case.
  function automatic logic [UnitW-1:0] any_case(input byte c);
    logic [UnitW-1:0] u;
    u = {8'h00, c};
    if (u >= CharUpperA && u <= CharUpperZ) begin
      u = u + CaseOffset;
    end
    if ($urandom_range(0, 1) == 1 && u >= 16'h0061 && u <= 16'h007A) begin
      u = u - CaseOffset;
    end
    return u;
  endfunction

  // One unit from a mix of ordinary, forbidden, boundary and non-ASCII values.
  function automatic logic [UnitW-1:0] pick_unit();
    logic [UnitW-1:0] bad_set[10];
    bad_set = '{CharSlash, CharBslash, CharColon, CharStar, CharQuest,
                CharQuote, CharLess, CharGreater, CharPipe, 16'h0000};
    case ($urandom_range(0, 11))
      0: return UnitW'($urandom);
      1: return bad_set[$urandom_range(0, 9)];
      2: return UnitW'($urandom_range(0, 31));
      3: return CharSpace;
      4: return CharDot;
      5: return UnitW'($urandom_range(16'h0030, 16'h0039));
      6: return {8'($urandom_range(1, 255)), 8'($urandom_range(16'h41, 16'h7A))};
      default: return UnitW'($urandom_range(16'h0021, 16'h007E));
    endcase
  endfunction

  // Builds a random name; most are near a device name, the rest are free-form.
  task automatic build_random_name();
    string words[6];
    string w;
    int    n;
    words = '{"con", "prn", "aux", "nul", "com", "lpt"};
    name_buf = {};
    if ($urandom_range(0, 99) < 55) begin
      w = words[$urandom_range(0, 5)];
      for (int i = 0; i < 3; i++) begin
        name_buf.push_back(any_case(w[i]));
      end
      // Occasionally spoil one letter.
      if ($urandom_range(0, 9) == 0) begin
        name_buf[$urandom_range(0, 2)] = pick_unit();
      end
      case ($urandom_range(0, 3))
        0: ;
        1: name_buf.push_back(UnitW'($urandom_range(16'h0030, 16'h0039)));
        2: name_buf.push_back(pick_unit());
        default: begin
          name_buf.push_back(UnitW'($urandom_range(16'h0031, 16'h0039)));
          name_buf.push_back(any_case("x"));
        end
      endcase
      if ($urandom_range(0, 1) == 1) begin
        name_buf.push_back(CharDot);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          name_buf.push_back($urandom_range(0, 3) == 0 ? pick_unit() : any_case("t"));
        end
      end
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        name_buf.push_back(pick_unit());
      end
    end
  endtask

  // Main stimulus and end of run.
  initial begin
    board          = new();
    items_sent     = 0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_code_unit   = '0;
    in_end_of_name = 1'b0;
    out_ready      = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed names: empty, device bases, edge spaces and dots, forbidden units.
    send_text("");
    send_text("a");
    send_text("CON");
    send_text("nUl.txt");
    send_text("Aux.");
    send_text("COM1");
    send_text("lpt9.log");
    send_text("COM0");
    send_text("LPTX");
    send_text("CONX");
    send_text("COM12");
    send_text(" a");
    send_text("a ");
    send_text("a.");
    send_text(".");
    send_text("..");
    send_text("a|b");
    send_text("q?\"<>");
    send_text("x/y\\z:*");
    name_buf = '{16'h0041, 16'h0000, 16'h0042};
    send_buffered_name();
    name_buf = '{16'h001F};
    send_buffered_name();
    name_buf = '{16'hFFFF, 16'h8000, 16'h7FFF};
    send_buffered_name();
    // Non-ASCII units whose low byte spells a device name.
    name_buf = '{16'h0143, 16'h006F, 16'h006E};
    send_buffered_name();
    send_text("averylongname.ext");

    // Long receiver hold-off while short names keep arriving.
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0) begin
        name_buf = {};
      end else begin
        name_buf = '{pick_unit()};
      end
      send_buffered_name();
    end

    // Random names, with one stretch where neither side idles.
    while (items_sent < 2000) begin
      quiet = (items_sent >= 900 && items_sent < 1300);
      build_random_name();
      send_buffered_name();
    end
    quiet    = 1'b0;
    in_valid = 1'b0;

    // Drain the outstanding verdicts, then watch for stray results.
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: file_name_safety_check_core.f
hw/rtl/fnsc_pkg.sv
hw/rtl/fnsc_tracker.sv
hw/rtl/file_name_safety_check_core.sv
tb/tb_file_name_safety_check_core.sv
